// ===== hdl/trfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfs_pkg
// Shared types, codes and helpers of the rectangle fill byte sequencer.
// ----------------------------------------------------------------------------
package trfs_pkg;

  // Default panel geometry in pixels
  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 160;

  // Request codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ORIENTATION = 2'd0;
  localparam cfg_idx_t CFG_COL_OFFSET  = 2'd1;
  localparam cfg_idx_t CFG_ROW_OFFSET  = 2'd2;

  // Panel command bytes
  localparam logic [7:0] CMD_COLUMN = 8'h2A;
  localparam logic [7:0] CMD_ROW    = 8'h2B;
  localparam logic [7:0] CMD_WRITE  = 8'h2C;

  // RGB565 field masks
  localparam logic [15:0] RED_MASK   = 16'hF800;
  localparam logic [15:0] GREEN_MASK = 16'h07E0;
  localparam logic [15:0] BLUE_MASK  = 16'h001F;

  // Positions within the window header
  typedef logic [3:0] hdr_idx_t;
  localparam hdr_idx_t HDR_COL_CMD      = 4'd0;
  localparam hdr_idx_t HDR_COL_FIRST_HI = 4'd1;
  localparam hdr_idx_t HDR_COL_FIRST_LO = 4'd2;
  localparam hdr_idx_t HDR_COL_FINAL_HI = 4'd3;
  localparam hdr_idx_t HDR_COL_FINAL_LO = 4'd4;
  localparam hdr_idx_t HDR_ROW_CMD      = 4'd5;
  localparam hdr_idx_t HDR_ROW_FIRST_HI = 4'd6;
  localparam hdr_idx_t HDR_ROW_FIRST_LO = 4'd7;
  localparam hdr_idx_t HDR_ROW_FINAL_HI = 4'd8;
  localparam hdr_idx_t HDR_ROW_FINAL_LO = 4'd9;
  localparam hdr_idx_t HDR_WRITE_CMD    = 4'd10;

  // Sequencer phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_PIXELS = 3'b100
  } phase_t;

  // Fill request as held in the input register
  typedef struct packed {
    logic        action;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] fill_width;
    logic [15:0] fill_height;
    logic [15:0] color;
  } fill_req_t;

  // Clipped drawing window handed to the sequencer
  typedef struct packed {
    logic        ok;
    logic [15:0] col_first;
    logic [15:0] col_final;
    logic [15:0] row_first;
    logic [15:0] row_final;
    logic [15:0] color_sw;
  } window_t;

  // Exchange red and blue fields of an RGB565 word
  function automatic logic [15:0] swap_red_blue(input logic [15:0] c);
    logic [15:0] r;
    r = ((c & RED_MASK) >> 11) | (c & GREEN_MASK) | ((c & BLUE_MASK) << 11);
    return r;
  endfunction

endpackage

// ===== hdl/trfs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfs_in_if
// Request channel: start or tick, with rectangle and color.
// ----------------------------------------------------------------------------
interface trfs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] x_start;
  logic [15:0] y_start;
  logic [15:0] fill_width;
  logic [15:0] fill_height;
  logic [15:0] color;

  modport source (
    output valid, action, x_start, y_start, fill_width, fill_height, color,
    input  ready
  );
  modport sink (
    input  valid, action, x_start, y_start, fill_width, fill_height, color,
    output ready
  );
endinterface

// ===== hdl/trfs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfs_out_if
// Byte channel toward the SPI serializer.
// ----------------------------------------------------------------------------
interface trfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last_byte;

  modport source (
    output valid, out_byte, is_data, last_byte,
    input  ready
  );
  modport sink (
    input  valid, out_byte, is_data, last_byte,
    output ready
  );
endinterface

// ===== hdl/trfs_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfs_cfg_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface trfs_cfg_if;
  logic                  valid;
  logic                  ready;
  trfs_pkg::cfg_idx_t    index;
  logic [7:0]            data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== hdl/tft_rect_fill_byte_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tft_rect_fill_byte_sequencer
// Rectangle fill byte source for an RGB565 SPI TFT panel.
//
// in_ch carries requests: a start latches a rectangle clipped to the screen
// (size set by orientation), a tick asks for the next SPI byte. out_ch
// returns one byte per tick while a fill is active: 0x2A and four column
// window bytes, 0x2B and four row window bytes, 0x2C, then two bytes per
// pixel. is_data gives the D/C level, last_byte marks the final pixel byte.
// cfg_ch writes orientation, column offset and row offset; write only when
// no request is in flight.
// A tick's byte passes through the input register and then the result register
// before it shows on out_ch. Throughput is one request per cycle while out_ch
// does not stall, set by the single register-to-register pass through clip and sequencer.
// Starts, rejected starts and idle ticks produce no byte.
// Reset clears the valid flags and configuration registers and returns the sequencer to idle.
// When out_ch stalls, the pending byte holds; one more request waits in the
// input register and in_ch.ready drops behind it.
// ----------------------------------------------------------------------------
module tft_rect_fill_byte_sequencer #(
  parameter int PANEL_WIDTH  = trfs_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = trfs_pkg::PANEL_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  trfs_in_if.sink            in_ch,
  trfs_out_if.source         out_ch,
  trfs_cfg_if.sink           cfg_ch
);

  localparam int PixW = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);

  logic [1:0]          orient_r;
  logic [7:0]          col_off_r;
  logic [7:0]          row_off_r;

  logic                req_vld_r;
  trfs_pkg::fill_req_t req_r;
  logic                in_xfer;
  logic                step;
  logic                slot_free;

  trfs_pkg::window_t   win;
  logic [PixW-1:0]     pixels;

  // A start never needs the result slot; a tick waits for it
  assign step      = req_vld_r && (req_r.action == trfs_pkg::ACT_START || slot_free);
  assign in_ch.ready = !req_vld_r || step;
  assign in_xfer   = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_xfer) begin
      req_vld_r <= 1'b1;
    end else if (step) begin
      req_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r.action      <= in_ch.action;
      req_r.x_start     <= in_ch.x_start;
      req_r.y_start     <= in_ch.y_start;
      req_r.fill_width  <= in_ch.fill_width;
      req_r.fill_height <= in_ch.fill_height;
      req_r.color       <= in_ch.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r  <= '0;
      col_off_r <= '0;
      row_off_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        trfs_pkg::CFG_ORIENTATION: orient_r  <= cfg_ch.data[1:0];
        trfs_pkg::CFG_COL_OFFSET:  col_off_r <= cfg_ch.data;
        trfs_pkg::CFG_ROW_OFFSET:  row_off_r <= cfg_ch.data;
        default: begin
          // unknown index: drop
        end
      endcase
    end
  end

  trfs_clip #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .PIX_W        (PixW)
  ) u_clip (
    .orientation (orient_r),
    .col_offset  (col_off_r),
    .row_offset  (row_off_r),
    .req         (req_r),
    .win         (win),
    .pixels      (pixels)
  );

  trfs_seq #(
    .PIX_W (PixW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .action      (req_r.action),
    .win         (win),
    .pixels      (pixels),
    .out_ready   (out_ch.ready),
    .slot_free   (slot_free),
    .out_vld     (out_ch.valid),
    .out_byte    (out_ch.out_byte),
    .out_is_data (out_ch.is_data),
    .out_last    (out_ch.last_byte)
  );

endmodule

// ===== hdl/trfs_clip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfs_clip
// Clips a fill request to the rotated screen and forms the address window.
// ----------------------------------------------------------------------------
module trfs_clip #(
  parameter int PANEL_WIDTH  = trfs_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = trfs_pkg::PANEL_HEIGHT_DEF,
  parameter int PIX_W        = 15
) (
  input  logic                [1:0]       orientation,
  input  logic                [7:0]       col_offset,
  input  logic                [7:0]       row_offset,
  input  trfs_pkg::fill_req_t             req,
  output trfs_pkg::window_t               win,
  output logic                [PIX_W-1:0] pixels
);

  localparam int DimMax = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int DimW   = $clog2(DimMax + 1);
  localparam logic [DimW-1:0] PwDim = DimW'(PANEL_WIDTH);
  localparam logic [DimW-1:0] PhDim = DimW'(PANEL_HEIGHT);

  logic [DimW-1:0]   scr_w;
  logic [DimW-1:0]   scr_h;
  logic              x_in;
  logic              y_in;
  logic [DimW-1:0]   room_w;
  logic [DimW-1:0]   room_h;
  logic [DimW-1:0]   w_clip;
  logic [DimW-1:0]   h_clip;
  logic [2*DimW-1:0] prod;

  // Odd orientations turn the panel on its side
  assign scr_w = orientation[0] ? PhDim : PwDim;
  assign scr_h = orientation[0] ? PwDim : PhDim;

  assign x_in = req.x_start < 16'(scr_w);
  assign y_in = req.y_start < 16'(scr_h);

  assign room_w = scr_w - req.x_start[DimW-1:0];
  assign room_h = scr_h - req.y_start[DimW-1:0];

  assign w_clip = (req.fill_width  > 16'(room_w)) ? room_w : req.fill_width[DimW-1:0];
  assign h_clip = (req.fill_height > 16'(room_h)) ? room_h : req.fill_height[DimW-1:0];

  assign prod   = (2*DimW)'(w_clip) * (2*DimW)'(h_clip);
  assign pixels = prod[PIX_W-1:0];

  always_comb begin
    win.ok        = x_in && y_in && (w_clip != '0) && (h_clip != '0);
    win.col_first = req.x_start + 16'(col_offset);
    win.col_final = req.x_start + 16'(w_clip) - 16'd1 + 16'(col_offset);
    win.row_first = req.y_start + 16'(row_offset);
    win.row_final = req.y_start + 16'(h_clip) - 16'd1 + 16'(row_offset);
    win.color_sw  = trfs_pkg::swap_red_blue(req.color);
  end

endmodule

// ===== hdl/trfs_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfs_seq
// Byte sequencer: window header, memory-write command, then pixel bytes,
// one byte per tick into the result register.
// ----------------------------------------------------------------------------
module trfs_seq #(
  parameter int PIX_W = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          action,
  input  trfs_pkg::window_t             win,
  input  logic              [PIX_W-1:0] pixels,
  input  logic                          out_ready,
  output logic                          slot_free,
  output logic                          out_vld,
  output logic              [7:0]       out_byte,
  output logic                          out_is_data,
  output logic                          out_last
);

  trfs_pkg::phase_t   phase_r,     phase_nxt;
  trfs_pkg::hdr_idx_t hdr_idx_r,   hdr_idx_nxt;
  trfs_pkg::window_t  win_r,       win_nxt;
  logic [PIX_W-1:0]   pix_left_r,  pix_left_nxt;
  logic               low_next_r,  low_next_nxt;
  logic               out_vld_r,   out_vld_nxt;
  logic [7:0]         out_byte_r,  out_byte_nxt;
  logic               out_data_r,  out_data_nxt;
  logic               out_last_r,  out_last_nxt;

  logic [7:0]         hdr_byte;
  logic               hdr_data;

  assign slot_free   = !out_vld_r || out_ready;
  assign out_vld     = out_vld_r;
  assign out_byte    = out_byte_r;
  assign out_is_data = out_data_r;
  assign out_last    = out_last_r;

  always_comb begin
    hdr_data = 1'b1;
    unique case (hdr_idx_r)
      trfs_pkg::HDR_COL_CMD: begin
        hdr_byte = trfs_pkg::CMD_COLUMN;
        hdr_data = 1'b0;
      end
      trfs_pkg::HDR_COL_FIRST_HI: hdr_byte = win_r.col_first[15:8];
      trfs_pkg::HDR_COL_FIRST_LO: hdr_byte = win_r.col_first[7:0];
      trfs_pkg::HDR_COL_FINAL_HI: hdr_byte = win_r.col_final[15:8];
      trfs_pkg::HDR_COL_FINAL_LO: hdr_byte = win_r.col_final[7:0];
      trfs_pkg::HDR_ROW_CMD: begin
        hdr_byte = trfs_pkg::CMD_ROW;
        hdr_data = 1'b0;
      end
      trfs_pkg::HDR_ROW_FIRST_HI: hdr_byte = win_r.row_first[15:8];
      trfs_pkg::HDR_ROW_FIRST_LO: hdr_byte = win_r.row_first[7:0];
      trfs_pkg::HDR_ROW_FINAL_HI: hdr_byte = win_r.row_final[15:8];
      trfs_pkg::HDR_ROW_FINAL_LO: hdr_byte = win_r.row_final[7:0];
      default: begin
        hdr_byte = trfs_pkg::CMD_WRITE;
        hdr_data = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    win_nxt      = win_r;
    pix_left_nxt = pix_left_r;
    low_next_nxt = low_next_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_byte_nxt = out_byte_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    if (step) begin
      if (action == trfs_pkg::ACT_START) begin
        // Latch only when idle and something is left after clipping
        if (phase_r == trfs_pkg::PH_IDLE && win.ok) begin
          win_nxt      = win;
          pix_left_nxt = pixels;
          low_next_nxt = 1'b0;
          hdr_idx_nxt  = trfs_pkg::HDR_COL_CMD;
          phase_nxt    = trfs_pkg::PH_HEADER;
        end
      end else begin
        unique case (phase_r)
          trfs_pkg::PH_HEADER: begin
            out_vld_nxt  = 1'b1;
            out_byte_nxt = hdr_byte;
            out_data_nxt = hdr_data;
            out_last_nxt = 1'b0;
            if (hdr_idx_r == trfs_pkg::HDR_WRITE_CMD) begin
              hdr_idx_nxt = trfs_pkg::HDR_COL_CMD;
              phase_nxt   = trfs_pkg::PH_PIXELS;
            end else begin
              hdr_idx_nxt = hdr_idx_r + 4'd1;
            end
          end
          trfs_pkg::PH_PIXELS: begin
            out_vld_nxt  = 1'b1;
            out_data_nxt = 1'b1;
            if (!low_next_r) begin
              out_byte_nxt = win_r.color_sw[15:8];
              out_last_nxt = 1'b0;
              low_next_nxt = 1'b1;
            end else begin
              out_byte_nxt = win_r.color_sw[7:0];
              low_next_nxt = 1'b0;
              if (pix_left_r <= PIX_W'(1)) begin
                pix_left_nxt = '0;
                out_last_nxt = 1'b1;
                phase_nxt    = trfs_pkg::PH_IDLE;
              end else begin
                pix_left_nxt = pix_left_r - PIX_W'(1);
                out_last_nxt = 1'b0;
              end
            end
          end
          default: begin
            // tick while idle: drop
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= trfs_pkg::PH_IDLE;
      hdr_idx_r  <= trfs_pkg::HDR_COL_CMD;
      pix_left_r <= '0;
      low_next_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      pix_left_r <= pix_left_nxt;
      low_next_r <= low_next_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    out_byte_r <= out_byte_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== test/tb_tft_rect_fill_byte_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tft_rect_fill_byte_sequencer
// Self-checking bench for the rectangle fill byte sequencer. A scoreboard
// clips each start against the current rotation, latches the window and
// predicts every SPI byte a tick draws out; returned bytes are compared in
// order. Directed corner cases come first, then randomized fill sequences
// under several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_tft_rect_fill_byte_sequencer;
  import trfs_pkg::*;

  localparam int       PANEL_W       = PANEL_WIDTH_DEF;
  localparam int       PANEL_H       = PANEL_HEIGHT_DEF;
  localparam int       SETTLE_CYCLES = 4;
  localparam int       TAIL_CYCLES   = 20;
  localparam int       LONG_HOLD     = 300;
  localparam int       PHASE_ITEMS   = 30;
  localparam int       LIMIT         = 1500000;
  localparam cfg_idx_t CFG_UNUSED    = 2'd3;

  typedef struct {
    logic [7:0] data_byte;
    logic       is_data;
    logic       last;
  } spi_byte_t;

  class fill_scoreboard;
    spi_byte_t   expected_q[$];
    phase_t      phase;
    hdr_idx_t    hdr_pos;
    logic [15:0] win_col_first;
    logic [15:0] win_col_final;
    logic [15:0] win_row_first;
    logic [15:0] win_row_final;
    int unsigned pix_remaining;
    logic [15:0] color_bgr;
    bit          low_due;
    logic [1:0]  rotation;
    logic [7:0]  col_shift;
    logic [7:0]  row_shift;
    int          errors;
    int          bytes_seen;

    function new();
      phase         = PH_IDLE;
      hdr_pos       = HDR_COL_CMD;
      win_col_first = '0;
      win_col_final = '0;
      win_row_first = '0;
      win_row_final = '0;
      pix_remaining = 0;
      color_bgr     = '0;
      low_due       = 1'b0;
      rotation      = '0;
      col_shift     = '0;
      row_shift     = '0;
      errors        = 0;
      bytes_seen    = 0;
    endfunction

    function int unsigned screen_cols();
      return rotation[0] ? PANEL_H : PANEL_W;
    endfunction

    function int unsigned screen_rows();
      return rotation[0] ? PANEL_W : PANEL_H;
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(cfg_idx_t idx, logic [7:0] val);
      case (idx)
        CFG_ORIENTATION: rotation = val[1:0];
        CFG_COL_OFFSET:  col_shift = val;
        CFG_ROW_OFFSET:  row_shift = val;
        default: ;
      endcase
    endfunction

    // Returns 1 when the transfer changed state or yields a byte.
    function bit note_request(fill_req_t r);
      spi_byte_t   b;
      int unsigned sw;
      int unsigned sh;
      int unsigned x;
      int unsigned y;
      int unsigned w;
      int unsigned h;
      if (r.action == ACT_START) begin
        if (phase != PH_IDLE) return 1'b0;
        sw = screen_cols();
        sh = screen_rows();
        x  = r.x_start;
        y  = r.y_start;
        w  = r.fill_width;
        h  = r.fill_height;
        if (x >= sw || y >= sh) return 1'b0;
        if (x + w > sw) w = sw - x;
        if (y + h > sh) h = sh - y;
        if (w == 0 || h == 0) return 1'b0;
        win_col_first = 16'(x + col_shift);
        win_col_final = 16'(x + w - 1 + col_shift);
        win_row_first = 16'(y + row_shift);
        win_row_final = 16'(y + h - 1 + row_shift);
        pix_remaining = w * h;
        color_bgr     = {r.color[4:0], r.color[10:5], r.color[15:11]};
        low_due       = 1'b0;
        hdr_pos       = HDR_COL_CMD;
        phase         = PH_HEADER;
        return 1'b1;
      end
      b.is_data = 1'b1;
      b.last    = 1'b0;
      if (phase == PH_HEADER) begin
        case (hdr_pos)
          HDR_COL_CMD: begin
            b.data_byte = CMD_COLUMN;
            b.is_data   = 1'b0;
          end
          HDR_COL_FIRST_HI: b.data_byte = win_col_first[15:8];
          HDR_COL_FIRST_LO: b.data_byte = win_col_first[7:0];
          HDR_COL_FINAL_HI: b.data_byte = win_col_final[15:8];
          HDR_COL_FINAL_LO: b.data_byte = win_col_final[7:0];
          HDR_ROW_CMD: begin
            b.data_byte = CMD_ROW;
            b.is_data   = 1'b0;
          end
          HDR_ROW_FIRST_HI: b.data_byte = win_row_first[15:8];
          HDR_ROW_FIRST_LO: b.data_byte = win_row_first[7:0];
          HDR_ROW_FINAL_HI: b.data_byte = win_row_final[15:8];
          HDR_ROW_FINAL_LO: b.data_byte = win_row_final[7:0];
          default: begin
            b.data_byte = CMD_WRITE;
            b.is_data   = 1'b0;
          end
        endcase
        if (hdr_pos >= HDR_WRITE_CMD) begin
          hdr_pos = HDR_COL_CMD;
          phase   = PH_PIXELS;
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end else if (phase == PH_PIXELS) begin
        if (!low_due) begin
          b.data_byte = color_bgr[15:8];
          low_due     = 1'b1;
        end else begin
          b.data_byte = color_bgr[7:0];
          low_due     = 1'b0;
          if (pix_remaining <= 1) begin
            pix_remaining = 0;
            b.last        = 1'b1;
            phase         = PH_IDLE;
          end else begin
            pix_remaining--;
          end
        end
      end else begin
        return 1'b0;
      end
      expected_q.push_back(b);
      return 1'b1;
    endfunction

    function void check_byte(logic [7:0] data_byte, logic is_data, logic last);
      spi_byte_t exp_b;
      bytes_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected byte %02h is_data %0b last_byte %0b",
                 $time, data_byte, is_data, last);
        errors++;
        return;
      end
      exp_b = expected_q.pop_front();
      if (data_byte !== exp_b.data_byte) begin
        $display("%0t: out_byte expected %02h actual %02h",
                 $time, exp_b.data_byte, data_byte);
        errors++;
      end
      if (is_data !== exp_b.is_data) begin
        $display("%0t: is_data expected %0b actual %0b", $time, exp_b.is_data, is_data);
        errors++;
      end
      if (last !== exp_b.last) begin
        $display("%0t: last_byte expected %0b actual %0b", $time, exp_b.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  trfs_in_if  in_ch ();
  trfs_out_if out_ch ();
  trfs_cfg_if cfg_ch ();

  tft_rect_fill_byte_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  fill_scoreboard fills = new();
  bit             quiet;
  bit             hold_long;
  int             items_taken;
  int             settings_used;
  int             cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count, fills.pending());
      $display("tft_rect_fill_byte_sequencer verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      fills.check_byte(out_ch.out_byte, out_ch.is_data, out_ch.last_byte);
  end

  // Byte sink: random stall bursts, one long hold-off on request.
  initial begin
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic fill_req_t rand_req(logic act);
    fill_req_t r;
    r.action      = act;
    r.x_start     = 16'($urandom);
    r.y_start     = 16'($urandom);
    r.fill_width  = 16'($urandom);
    r.fill_height = 16'($urandom);
    r.color       = 16'($urandom);
    return r;
  endfunction

  task automatic send_item(input fill_req_t r);
    in_ch.valid       <= 1'b1;
    in_ch.action      <= r.action;
    in_ch.x_start     <= r.x_start;
    in_ch.y_start     <= r.y_start;
    in_ch.fill_width  <= r.fill_width;
    in_ch.fill_height <= r.fill_height;
    in_ch.color       <= r.color;
    do @(posedge clk); while (!in_ch.ready);
    if (fills.note_request(r)) items_taken++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic start_req(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] w, input logic [15:0] h,
                           input logic [15:0] c);
    fill_req_t r;
    r             = rand_req(ACT_START);
    r.x_start     = x;
    r.y_start     = y;
    r.fill_width  = w;
    r.fill_height = h;
    r.color       = c;
    send_item(r);
  endtask

  task automatic drain_ticks();
    while (fills.busy()) send_item(rand_req(ACT_TICK));
  endtask

  task automatic paint_box(input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] w, input logic [15:0] h,
                           input logic [15:0] c);
    start_req(x, y, w, h, c);
    drain_ticks();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (fills.pending() != 0);
  endtask

  task automatic apply_settings(input logic [1:0] rot, input logic [7:0] col,
                                input logic [7:0] row, input bit stray);
    cfg_idx_t   idx[4];
    logic [7:0] val[4];
    int         n;
    idx = '{CFG_ORIENTATION, CFG_COL_OFFSET, CFG_ROW_OFFSET, CFG_UNUSED};
    val = '{{6'($urandom), rot}, col, row, 8'($urandom)};
    n   = stray ? 4 : 3;
    wait_drained();
    // a start leaves no byte behind; let it clear the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < n; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      fills.write_reg(idx[i], val[i]);
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_sequence();
    fill_req_t   r;
    int unsigned sw;
    int unsigned sh;
    int          kind;
    sw   = fills.screen_cols();
    sh   = fills.screen_rows();
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      r         = rand_req(ACT_START);
      r.x_start = 16'($urandom_range(0, sw - 1));
      r.y_start = 16'($urandom_range(0, sh - 1));
      case ($urandom_range(0, 15))
        0: begin
          // full-range width clipped at the right edge
          r.x_start     = 16'(sw - $urandom_range(1, 4));
          r.fill_height = 16'($urandom_range(1, 2));
        end
        1: begin
          // full-range height clipped at the bottom edge
          r.y_start    = 16'(sh - $urandom_range(1, 4));
          r.fill_width = 16'($urandom_range(1, 2));
        end
        2: begin
          r.fill_width  = $urandom_range(0, 1) ? 16'd0 : r.fill_width;
          r.fill_height = (r.fill_width != 0) ? 16'd0 : r.fill_height;
        end
        default: begin
          r.fill_width  = 16'($urandom_range(1, 3));
          r.fill_height = 16'($urandom_range(1, 3));
        end
      endcase
      send_item(r);
      while (fills.busy()) begin
        if ($urandom_range(0, 19) == 0) send_item(rand_req(ACT_START));
        else send_item(rand_req(ACT_TICK));
      end
      if ($urandom_range(0, 3) == 0) send_item(rand_req(ACT_TICK));
    end else if (kind <= 8) begin
      // noise: fields over their full range, mostly dropped
      send_item(rand_req(logic'($urandom_range(0, 1))));
      drain_ticks();
    end else begin
      wait_drained();
    end
  endtask

  initial begin
    logic [1:0] rot_set[5];
    logic [7:0] col_set[5];
    logic [7:0] row_set[5];
    int         mark;
    rot_set = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1};
    col_set = '{8'd0, 8'd255, 8'($urandom), 8'd0, 8'($urandom)};
    row_set = '{8'd0, 8'd255, 8'($urandom), 8'd255, 8'($urandom)};
    quiet              = 1'b0;
    hold_long          = 1'b0;
    items_taken        = 0;
    settings_used      = 0;
    cycle_count        = 0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_START;
    in_ch.x_start     <= '0;
    in_ch.y_start     <= '0;
    in_ch.fill_width  <= '0;
    in_ch.fill_height <= '0;
    in_ch.color       <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_ORIENTATION;
    cfg_ch.data       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick while idle, smallest fill, start while busy, extreme clipping
    send_item(rand_req(ACT_TICK));
    start_req(16'd0, 16'd0, 16'd1, 16'd1, 16'hF800);
    start_req(16'd0, 16'd0, 16'd2, 16'd2, 16'h1234);
    drain_ticks();
    send_item(rand_req(ACT_TICK));
    paint_box(16'd127, 16'd159, 16'hFFFF, 16'hFFFF, 16'h001F);
    // dropped: off screen or empty after clipping
    start_req(16'd128, 16'd0, 16'd1, 16'd1, 16'hFFFF);
    start_req(16'd0, 16'd160, 16'd1, 16'd1, 16'hFFFF);
    start_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    start_req(16'd5, 16'd5, 16'd0, 16'd4, 16'hAAAA);
    start_req(16'd5, 16'd5, 16'd4, 16'd0, 16'h5555);
    send_item(rand_req(ACT_TICK));

    apply_settings(2'd1, 8'd255, 8'd255, 1'b1);
    paint_box(16'd159, 16'd127, 16'd2, 16'd3, 16'hFFFF);
    paint_box(16'd128, 16'd0, 16'd1, 16'd2, 16'h07E0);
    start_req(16'd0, 16'd128, 16'd1, 16'd1, 16'h0001);
    apply_settings(2'd3, 8'd0, 8'd0, 1'b0);
    paint_box(16'd0, 16'd0, 16'd3, 16'd1, 16'h0000);

    for (int p = 0; p < 5; p++) begin
      apply_settings(rot_set[p], col_set[p], row_set[p], p == 2);
      if (p == 1) begin
        // hold the sink off while ticks keep coming
        hold_long = 1'b1;
        paint_box(16'd0, 16'd0, 16'd4, 16'd4, 16'($urandom));
        wait_drained();
      end
      mark = items_taken;
      while (items_taken - mark < PHASE_ITEMS) random_sequence();
    end

    // no stalls from here on; one fill clipped at the far corner
    quiet = 1'b1;
    apply_settings(2'd0, 8'($urandom), 8'($urandom), 1'b0);
    paint_box(16'd124, 16'd157, 16'hFFFF, 16'hFFFF, 16'($urandom));
    repeat (3) random_sequence();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d transfers took effect, %0d bytes checked, %0d register settings",
             items_taken, fills.bytes_seen, settings_used);
    $display("covered idle ticks, busy starts, dropped and clipped fills, all rotations");
    if (fills.errors == 0) begin
      $display("tft_rect_fill_byte_sequencer verification clean");
    end else begin
      $display("%0d mismatches", fills.errors);
      $display("tft_rect_fill_byte_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/trfs_pkg.sv
hdl/trfs_in_if.sv
hdl/trfs_out_if.sv
hdl/trfs_cfg_if.sv
hdl/trfs_clip.sv
hdl/trfs_seq.sv
hdl/tft_rect_fill_byte_sequencer.sv
test/tb_tft_rect_fill_byte_sequencer.sv
